// ----- hw/rtl/ac_pkg.sv -----
`default_nettype none
package ac_pkg;

    // controller to datapath command
    typedef logic [4:0] t_cmd;

    localparam t_cmd CMD_NOP       = 5'd0;
    localparam t_cmd CMD_LOAD      = 5'd1;
    localparam t_cmd CMD_SWEEP     = 5'd2;
    localparam t_cmd CMD_SWEND     = 5'd3;
    localparam t_cmd CMD_INS_RD    = 5'd4;
    localparam t_cmd CMD_INS_WR    = 5'd5;
    localparam t_cmd CMD_M_RD      = 5'd6;
    localparam t_cmd CMD_M_FAIL    = 5'd7;
    localparam t_cmd CMD_M_FTAKE   = 5'd8;
    localparam t_cmd CMD_M_TAG     = 5'd9;
    localparam t_cmd CMD_M_END     = 5'd10;
    localparam t_cmd CMD_M_MISS    = 5'd11;
    localparam t_cmd CMD_C_INIT    = 5'd12;
    localparam t_cmd CMD_C_POP     = 5'd13;
    localparam t_cmd CMD_C_PTAKE   = 5'd14;
    localparam t_cmd CMD_C_CRD     = 5'd15;
    localparam t_cmd CMD_C_CHILD   = 5'd16;
    localparam t_cmd CMD_C_FTAKE   = 5'd17;
    localparam t_cmd CMD_C_WRD     = 5'd18;
    localparam t_cmd CMD_C_SETLINK = 5'd19;
    localparam t_cmd CMD_C_FAIL    = 5'd20;
    localparam t_cmd CMD_C_WLINK   = 5'd21;
    localparam t_cmd CMD_C_NEXT    = 5'd22;
    localparam t_cmd CMD_C_DONE    = 5'd23;

    // operation codes of the func field
    localparam logic [1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [1:0] FUNC_INSERT  = 2'd1;
    localparam logic [1:0] FUNC_COMPILE = 2'd2;
    localparam logic [1:0] FUNC_MATCH   = 2'd3;

    // datapath to controller status
    typedef struct packed {
        logic child_zero;
        logic u_root;
        logic uf_root;
        logic hops_lim;
        logic q_empty;
        logic ch_last;
        logic sweep_last;
    } t_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/ac_if.sv -----
`default_nettype none
interface ac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_value;
    logic [7:0] pattern_id;
    logic       last_byte;

    modport source (output valid, func, char_value, pattern_id, last_byte, input ready);
    modport sink   (input valid, func, char_value, pattern_id, last_byte, output ready);
endinterface

interface ac_out_if;
    logic       valid;
    logic       ready;
    logic       match_valid;
    logic [7:0] matched_pattern;
    logic       status;

    modport source (output valid, match_valid, matched_pattern, status, input ready);
    modport sink   (input valid, match_valid, matched_pattern, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/aho_corasick_matcher.sv -----
`default_nettype none
// Insert: reads the child entry, then adds the node and end tag as needed. Match: reads
// the child entry, follows failure links while it misses, then reads the end tag. Compile:
// walks the trie breadth first, its time set by the single child-table read port.
// Clear: sweeps the tables, then replies. One item in flight; result held until taken.
// After reset and on clear the child table, end tags and failure links are swept,
// one child entry a cycle.
module aho_corasick_matcher #(
    parameter int MAX_NODES = 256,
    parameter int ALPHABET  = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ac_in_if.sink     i_in,
    ac_out_if.source  o_out
);

    ac_pkg::t_cmd cmd;
    ac_pkg::t_sts sts;

    ac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ac_dp #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_char_value      (i_in.char_value),
        .i_pattern_id      (i_in.pattern_id),
        .i_last_byte       (i_in.last_byte),
        .o_sts             (sts),
        .o_match_valid     (o_out.match_valid),
        .o_matched_pattern (o_out.matched_pattern),
        .o_status          (o_out.status)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input taken while a result waits");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready held after accept");

    a_match_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.match_valid && o_out.status))
        else $error("match and overflow reported together");

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (cmd == ac_pkg::CMD_LOAD))
        else $error("accepted item not loaded");

endmodule
`default_nettype wire

// ----- hw/rtl/ac_ctrl.sv -----
`default_nettype none
module ac_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_in_func,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire ac_pkg::t_sts  i_sts,
    output ac_pkg::t_cmd       o_cmd
);

    localparam logic [4:0] S_SWEEP   = 5'd0;
    localparam logic [4:0] S_SWEND   = 5'd1;
    localparam logic [4:0] S_IDLE    = 5'd2;
    localparam logic [4:0] S_OUT     = 5'd3;
    localparam logic [4:0] S_INS_RD  = 5'd4;
    localparam logic [4:0] S_INS_WR  = 5'd5;
    localparam logic [4:0] S_M_RD    = 5'd6;
    localparam logic [4:0] S_M_CHK   = 5'd7;
    localparam logic [4:0] S_M_FTAKE = 5'd8;
    localparam logic [4:0] S_M_END   = 5'd9;
    localparam logic [4:0] S_C_INIT  = 5'd10;
    localparam logic [4:0] S_C_POP   = 5'd11;
    localparam logic [4:0] S_C_PTAKE = 5'd12;
    localparam logic [4:0] S_C_CRD   = 5'd13;
    localparam logic [4:0] S_C_CCHK  = 5'd14;
    localparam logic [4:0] S_C_FTAKE = 5'd15;
    localparam logic [4:0] S_C_WRD   = 5'd16;
    localparam logic [4:0] S_C_WCHK  = 5'd17;
    localparam logic [4:0] S_C_WLINK = 5'd18;

    logic [4:0] r_state, n_state;
    logic       r_reply, n_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_reply <= n_reply;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_reply     = r_reply;
        o_cmd       = ac_pkg::CMD_NOP;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_SWEEP: begin
                o_cmd = ac_pkg::CMD_SWEEP;
                if (i_sts.sweep_last) n_state = S_SWEND;
            end
            S_SWEND: begin
                o_cmd   = ac_pkg::CMD_SWEND;
                n_state = r_reply ? S_OUT : S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = ac_pkg::CMD_LOAD;
                    case (i_in_func)
                        ac_pkg::FUNC_CLEAR: begin
                            n_state = S_SWEEP;
                            n_reply = 1'b1;
                        end
                        ac_pkg::FUNC_INSERT:  n_state = S_INS_RD;
                        ac_pkg::FUNC_COMPILE: n_state = S_C_INIT;
                        default:              n_state = S_M_RD;
                    endcase
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            S_INS_RD: begin
                o_cmd   = ac_pkg::CMD_INS_RD;
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                o_cmd   = ac_pkg::CMD_INS_WR;
                n_state = S_OUT;
            end
            S_M_RD: begin
                o_cmd   = ac_pkg::CMD_M_RD;
                n_state = S_M_CHK;
            end
            S_M_CHK: begin
                if (i_sts.child_zero && !i_sts.u_root && !i_sts.hops_lim) begin
                    o_cmd   = ac_pkg::CMD_M_FAIL;
                    n_state = S_M_FTAKE;
                end else if (i_sts.child_zero) begin
                    o_cmd   = ac_pkg::CMD_M_MISS;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = ac_pkg::CMD_M_TAG;
                    n_state = S_M_END;
                end
            end
            S_M_FTAKE: begin
                o_cmd   = ac_pkg::CMD_M_FTAKE;
                n_state = S_M_RD;
            end
            S_M_END: begin
                o_cmd   = ac_pkg::CMD_M_END;
                n_state = S_OUT;
            end
            S_C_INIT: begin
                o_cmd   = ac_pkg::CMD_C_INIT;
                n_state = S_C_POP;
            end
            S_C_POP: begin
                if (i_sts.q_empty) begin
                    o_cmd   = ac_pkg::CMD_C_DONE;
                    n_state = S_OUT;
                end else begin
                    o_cmd   = ac_pkg::CMD_C_POP;
                    n_state = S_C_PTAKE;
                end
            end
            S_C_PTAKE: begin
                o_cmd   = ac_pkg::CMD_C_PTAKE;
                n_state = S_C_CRD;
            end
            S_C_CRD: begin
                o_cmd   = ac_pkg::CMD_C_CRD;
                n_state = S_C_CCHK;
            end
            S_C_CCHK: begin
                if (i_sts.child_zero) begin
                    o_cmd   = ac_pkg::CMD_C_NEXT;
                    n_state = i_sts.ch_last ? S_C_POP : S_C_CRD;
                end else begin
                    o_cmd   = ac_pkg::CMD_C_CHILD;
                    n_state = i_sts.u_root ? S_C_WLINK : S_C_FTAKE;
                end
            end
            S_C_FTAKE: begin
                o_cmd   = ac_pkg::CMD_C_FTAKE;
                n_state = S_C_WRD;
            end
            S_C_WRD: begin
                o_cmd   = ac_pkg::CMD_C_WRD;
                n_state = S_C_WCHK;
            end
            S_C_WCHK: begin
                if (!i_sts.child_zero) begin
                    o_cmd   = ac_pkg::CMD_C_SETLINK;
                    n_state = S_C_WLINK;
                end else if (i_sts.uf_root || i_sts.hops_lim) begin
                    n_state = S_C_WLINK;
                end else begin
                    o_cmd   = ac_pkg::CMD_C_FAIL;
                    n_state = S_C_FTAKE;
                end
            end
            S_C_WLINK: begin
                o_cmd   = ac_pkg::CMD_C_WLINK;
                n_state = i_sts.ch_last ? S_C_POP : S_C_CRD;
            end
            default: n_state = S_SWEEP;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ac_dp.sv -----
`default_nettype none
module ac_dp #(
    parameter int MAX_NODES = 256,
    parameter int ALPHABET  = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ac_pkg::t_cmd  i_cmd,
    input  wire logic [7:0]    i_char_value,
    input  wire logic [7:0]    i_pattern_id,
    input  wire logic          i_last_byte,
    output ac_pkg::t_sts       o_sts,
    output logic               o_match_valid,
    output logic [7:0]         o_matched_pattern,
    output logic               o_status
);

    localparam int NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CW    = $clog2(ALPHABET);
    localparam int DEPTH = MAX_NODES * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ALPHA_A  = AW'(ALPHABET);
    localparam logic [NW:0]   NODES_C  = (NW+1)'(MAX_NODES);
    localparam logic [NW-1:0] NODE_TOP = NW'(MAX_NODES - 1);
    localparam logic [CW-1:0] CHAR_TOP = CW'(ALPHABET - 1);

    // child table, failure links, end tags, breadth-first queue
    logic [NW-1:0] r_child_mem [DEPTH];
    logic [NW-1:0] r_fail_mem  [MAX_NODES];
    logic [8:0]    r_tag_mem   [MAX_NODES];
    logic [NW-1:0] r_queue_mem [MAX_NODES];

    logic [CW-1:0] w_fold [256];

    logic [CW-1:0] r_ch, r_cc, r_sc;
    logic [7:0]    r_id;
    logic          r_last;
    logic [NW:0]   r_count, r_hops, r_head, r_tail;
    logic [NW-1:0] r_icur, r_mnode, r_u, r_uf, r_v, r_link, r_sn;
    logic [NW-1:0] r_crd, r_frd, r_qrd;
    logic [8:0]    r_trd;
    logic [AW-1:0] r_caddr;
    logic          r_mvalid, r_status;
    logic [7:0]    r_mpat;

    logic [NW-1:0] node_sel, ins_node, fail_raddr;
    logic [CW-1:0] char_sel;
    logic [AW-1:0] c_raddr;
    logic          ins_new, ins_drop;
    logic          c_we, t_we, f_we, q_we;
    logic [AW-1:0] c_waddr;
    logic [NW-1:0] c_wdata, t_waddr, f_waddr, f_wdata, q_waddr, q_wdata;
    logic [8:0]    t_wdata;

    // fold the byte into the alphabet
    for (genvar g = 0; g < 256; g++) begin : g_fold
        assign w_fold[g] = CW'(g % ALPHABET);
    end

    always_comb begin
        node_sel = r_u;
        char_sel = r_ch;
        case (i_cmd)
            ac_pkg::CMD_SWEEP:  begin node_sel = r_sn;   char_sel = r_sc; end
            ac_pkg::CMD_INS_RD: begin node_sel = r_icur; char_sel = r_ch; end
            ac_pkg::CMD_C_CRD:  begin node_sel = r_u;    char_sel = r_cc; end
            ac_pkg::CMD_C_WRD:  begin node_sel = r_uf;   char_sel = r_cc; end
            default: ;
        endcase
    end

    assign c_raddr    = AW'(node_sel) * ALPHA_A + AW'(char_sel);
    assign fail_raddr = (i_cmd == ac_pkg::CMD_C_FAIL) ? r_uf : r_u;

    assign ins_new  = (r_crd == '0);
    assign ins_drop = ins_new && (r_count >= NODES_C);
    assign ins_node = ins_new ? r_count[NW-1:0] : r_crd;

    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_caddr;
        c_wdata = r_count[NW-1:0];
        t_we    = 1'b0;
        t_waddr = ins_node;
        t_wdata = {1'b1, r_id};
        f_we    = 1'b0;
        f_waddr = r_v;
        f_wdata = r_link;
        q_we    = 1'b0;
        q_waddr = r_tail[NW-1:0];
        q_wdata = r_crd;
        case (i_cmd)
            ac_pkg::CMD_SWEEP: begin
                c_we    = 1'b1;
                c_waddr = c_raddr;
                c_wdata = '0;
                t_we    = 1'b1;
                t_waddr = r_sn;
                t_wdata = '0;
                f_we    = 1'b1;
                f_waddr = r_sn;
                f_wdata = '0;
            end
            ac_pkg::CMD_INS_WR: begin
                c_we = ins_new && !ins_drop;
                t_we = r_last && !ins_drop;
            end
            ac_pkg::CMD_C_INIT: begin
                f_we    = 1'b1;
                f_waddr = '0;
                f_wdata = '0;
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '0;
            end
            ac_pkg::CMD_C_CHILD: q_we = (r_tail < NODES_C);
            ac_pkg::CMD_C_WLINK: f_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_crd   <= r_child_mem[c_raddr];
        r_caddr <= c_raddr;
        if (c_we) r_child_mem[c_waddr] <= c_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_frd <= r_fail_mem[fail_raddr];
        if (f_we) r_fail_mem[f_waddr] <= f_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_trd <= r_tag_mem[r_crd];
        if (t_we) r_tag_mem[t_waddr] <= t_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_qrd <= r_queue_mem[r_head[NW-1:0]];
        if (q_we) r_queue_mem[q_waddr] <= q_wdata;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            ac_pkg::CMD_LOAD: begin
                r_ch     <= w_fold[i_char_value];
                r_id     <= i_pattern_id;
                r_last   <= i_last_byte;
                r_u      <= r_mnode;
                r_hops   <= '0;
                r_mvalid <= 1'b0;
                r_mpat   <= '0;
                r_status <= 1'b0;
            end
            ac_pkg::CMD_INS_WR:  r_status <= ins_drop;
            ac_pkg::CMD_M_FAIL:  r_hops   <= r_hops + 1'b1;
            ac_pkg::CMD_M_FTAKE: r_u      <= r_frd;
            ac_pkg::CMD_M_TAG:   r_v      <= r_crd;
            ac_pkg::CMD_M_END: begin
                r_mvalid <= r_trd[8];
                r_mpat   <= r_trd[8] ? r_trd[7:0] : 8'd0;
            end
            ac_pkg::CMD_C_PTAKE: begin
                r_u  <= r_qrd;
                r_cc <= '0;
            end
            ac_pkg::CMD_C_CHILD: begin
                r_v    <= r_crd;
                r_link <= '0;
                r_hops <= '0;
            end
            ac_pkg::CMD_C_FTAKE:   r_uf   <= r_frd;
            ac_pkg::CMD_C_SETLINK: r_link <= r_crd;
            ac_pkg::CMD_C_FAIL:    r_hops <= r_hops + 1'b1;
            ac_pkg::CMD_C_WLINK:   r_cc   <= r_cc + 1'b1;
            ac_pkg::CMD_C_NEXT:    r_cc   <= r_cc + 1'b1;
            default: ;
        endcase
    end

    // trie control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sn    <= '0;
            r_sc    <= '0;
            r_count <= (NW+1)'(1);
            r_icur  <= '0;
            r_mnode <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            case (i_cmd)
                ac_pkg::CMD_SWEEP: begin
                    if (r_sc == CHAR_TOP) begin
                        r_sc <= '0;
                        r_sn <= r_sn + 1'b1;
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end
                ac_pkg::CMD_SWEND: begin
                    r_sn    <= '0;
                    r_sc    <= '0;
                    r_count <= (NW+1)'(1);
                    r_icur  <= '0;
                    r_mnode <= '0;
                end
                ac_pkg::CMD_INS_WR: begin
                    if (ins_new && !ins_drop) r_count <= r_count + 1'b1;
                    if (r_last || ins_drop) begin
                        r_icur <= r_last ? '0 : r_icur;
                    end else begin
                        r_icur <= ins_node;
                    end
                end
                ac_pkg::CMD_M_MISS: r_mnode <= '0;
                ac_pkg::CMD_M_END:  r_mnode <= r_last ? '0 : r_v;
                ac_pkg::CMD_C_INIT: begin
                    r_head <= '0;
                    r_tail <= (NW+1)'(1);
                end
                ac_pkg::CMD_C_POP: r_head <= r_head + 1'b1;
                ac_pkg::CMD_C_CHILD: begin
                    if (r_tail < NODES_C) r_tail <= r_tail + 1'b1;
                end
                ac_pkg::CMD_C_DONE: r_mnode <= '0;
                default: ;
            endcase
        end
    end

    assign o_sts.child_zero = (r_crd == '0);
    assign o_sts.u_root     = (r_u == '0);
    assign o_sts.uf_root    = (r_uf == '0);
    assign o_sts.hops_lim   = (r_hops == NODES_C);
    assign o_sts.q_empty    = (r_head == r_tail);
    assign o_sts.ch_last    = (r_cc == CHAR_TOP);
    assign o_sts.sweep_last = (r_sn == NODE_TOP) && (r_sc == CHAR_TOP);

    assign o_match_valid     = r_mvalid;
    assign o_matched_pattern = r_mpat;
    assign o_status          = r_status;

endmodule
`default_nettype wire
